@@ rtl/core/bcd_frequency_reply_parser_assert.svh @@
// ----------------------------------------------------------------------------
// bcd frequency reply parser assertion macros
// concurrent checks, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef BCD_FREQUENCY_REPLY_PARSER_ASSERT_SVH
`define BCD_FREQUENCY_REPLY_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// implication in the same cycle
`define BFRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication on the following cycle
`define BFRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BFRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define BFRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/bfrp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfrp_pkg
// shared types and constants of the bcd frequency reply parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfrp_pkg;

    localparam int FREQ_W = 34;

    typedef logic [7:0]        t_byte;
    typedef logic [1:0]        t_status;
    typedef logic [FREQ_W-1:0] t_freq;
    typedef logic              t_cfg_idx;

    // result codes
    localparam t_status ST_FREQ = 2'd0;
    localparam t_status ST_OK   = 2'd1;
    localparam t_status ST_NG   = 2'd2;
    localparam t_status ST_BAD  = 2'd3;

    // frame bytes and commands
    localparam t_byte BYTE_PRE   = 8'hFE;
    localparam t_byte BYTE_END   = 8'hFD;
    localparam t_byte CMD_FREQ   = 8'h03;
    localparam t_byte CMD_ACK_OK = 8'hFB;
    localparam t_byte CMD_ACK_NG = 8'hFA;
    localparam t_byte NIB_MASK   = 8'h0F;

    // decimal weights
    localparam t_freq PAIR_SCALE  = t_freq'(100);
    localparam t_freq DIGIT_SCALE = t_freq'(10);

    // configuration register indexes and reset values
    localparam t_cfg_idx CFG_CTRL_ADDR = 1'b0;
    localparam t_cfg_idx CFG_RIG_ADDR  = 1'b1;
    localparam t_byte    CTRL_ADDR_RST = 8'hE0;
    localparam t_byte    RIG_ADDR_RST  = 8'h00;

endpackage

`default_nettype wire

@@ rtl/core/bfrp_queue.sv @@
// ----------------------------------------------------------------------------
// bfrp_queue
// two-entry job queue between frame front end and decode back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfrp_queue #(
    parameter int WIDTH = 42
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

`default_nettype wire

@@ rtl/core/bfrp_front.sv @@
// ----------------------------------------------------------------------------
// bfrp_front
// frame tracking, address check and classification of received bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfrp_front #(
    parameter int FREQ_BYTES = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire bfrp_pkg::t_byte                i_rx_byte,
    input  wire logic                           i_cfg_we,
    input  wire bfrp_pkg::t_cfg_idx             i_cfg_index,
    input  wire bfrp_pkg::t_byte                i_cfg_data,
    input  wire logic                           i_q_full,
    output logic                                o_in_stall,
    output logic                                o_push,
    output bfrp_pkg::t_status                   o_job_status,
    output logic [FREQ_BYTES-1:0][7:0]          o_job_digits
);
    import bfrp_pkg::*;

    localparam int CNTW = $clog2(FREQ_BYTES + 2);
    localparam int IDXW = $clog2(FREQ_BYTES);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(FREQ_BYTES);
    localparam logic [CNTW-1:0] CNT_OVER = CNTW'(FREQ_BYTES + 1);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_PRE1 = 3'd1;
    localparam logic [2:0] PH_DEST = 3'd2;
    localparam logic [2:0] PH_SRC  = 3'd3;
    localparam logic [2:0] PH_CMD  = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;

    logic [2:0]                r_phase;
    logic [2:0]                n_phase;
    logic                      r_match;
    logic                      n_match;
    t_byte                     r_cmd;
    t_byte                     n_cmd;
    logic [CNTW-1:0]           r_cnt;
    logic [CNTW-1:0]           n_cnt;
    logic [FREQ_BYTES-1:0][7:0] r_digits;
    logic                      digit_we;
    t_byte                     r_ctrl_addr;
    t_byte                     r_rig_addr;
    logic                      accept;

    function automatic t_status finish_status(t_byte cmd, logic [CNTW-1:0] cnt);
        t_status st;
        st = ST_BAD;
        if (cmd == CMD_FREQ && cnt == CNT_FULL) begin
            st = ST_FREQ;
        end else if (cmd == CMD_ACK_OK && cnt == '0) begin
            st = ST_OK;
        end else if (cmd == CMD_ACK_NG && cnt == '0) begin
            st = ST_NG;
        end
        return st;
    endfunction

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        n_phase      = r_phase;
        n_match      = r_match;
        n_cmd        = r_cmd;
        n_cnt        = r_cnt;
        o_push       = 1'b0;
        o_job_status = ST_BAD;
        digit_we     = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == BYTE_PRE) begin
                        n_phase = PH_PRE1;
                    end
                end
                PH_PRE1: begin
                    n_phase = (i_rx_byte == BYTE_PRE) ? PH_DEST : PH_IDLE;
                end
                PH_DEST: begin
                    if (i_rx_byte == BYTE_END) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_match = (i_rx_byte == r_ctrl_addr);
                        n_phase = PH_SRC;
                    end
                end
                PH_SRC: begin
                    if (i_rx_byte == BYTE_END) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_match = r_match && (i_rx_byte == r_rig_addr);
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    if (i_rx_byte == BYTE_END) begin
                        // header without command byte
                        n_phase = PH_IDLE;
                        o_push  = r_match;
                    end else begin
                        n_cmd   = i_rx_byte;
                        n_cnt   = '0;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (i_rx_byte == BYTE_END) begin
                        n_phase      = PH_IDLE;
                        o_push       = r_match;
                        o_job_status = finish_status(r_cmd, r_cnt);
                    end else if (r_cnt < CNT_FULL) begin
                        digit_we = 1'b1;
                        n_cnt    = r_cnt + CNTW'(1);
                    end else begin
                        n_cnt = CNT_OVER;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_match <= 1'b0;
            r_cmd   <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_cmd   <= n_cmd;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_addr <= CTRL_ADDR_RST;
            r_rig_addr  <= RIG_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CTRL_ADDR: r_ctrl_addr <= i_cfg_data;
                CFG_RIG_ADDR:  r_rig_addr  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // digit bytes, in arrival order
    always_ff @(posedge i_clk) begin
        if (digit_we) begin
            r_digits[r_cnt[IDXW-1:0]] <= i_rx_byte;
        end
    end

    assign o_job_digits = r_digits;

endmodule

`default_nettype wire

@@ rtl/core/bfrp_back.sv @@
// ----------------------------------------------------------------------------
// bfrp_back
// bcd frequency decode and result output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfrp_back #(
    parameter int FREQ_BYTES = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_valid,
    input  wire bfrp_pkg::t_status         i_q_status,
    input  wire logic [FREQ_BYTES-1:0][7:0] i_q_digits,
    input  wire logic                      i_out_stall,
    output logic                           o_pop,
    output logic                           o_out_valid,
    output bfrp_pkg::t_status              o_status,
    output bfrp_pkg::t_freq                o_frequency
);
    import bfrp_pkg::*;

    localparam int IDXW = $clog2(FREQ_BYTES);
    localparam logic [IDXW-1:0] LAST_STEP = IDXW'(FREQ_BYTES - 1);

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_CALC = 2'd1;
    localparam logic [1:0] BK_DONE = 2'd2;

    logic [1:0]                 r_state;
    logic [IDXW-1:0]            r_step;
    logic [FREQ_BYTES-1:0][7:0] r_sh;
    t_freq                      r_acc;
    t_freq                      pair_val;
    t_byte                      top_byte;
    logic                       out_free;
    logic                       out_load;
    logic                       r_out_valid;
    t_status                    r_status;
    t_freq                      r_freq;

    assign out_free = !r_out_valid || !i_out_stall;
    assign top_byte = r_sh[FREQ_BYTES-1];
    assign pair_val = t_freq'(top_byte & NIB_MASK) + t_freq'(top_byte[7:4]) * DIGIT_SCALE;

    always_comb begin
        o_pop = 1'b0;
        if (r_state == BK_IDLE && i_q_valid) begin
            o_pop = (i_q_status == ST_FREQ) || out_free;
        end
    end

    // a new result enters the output register only once it is free
    assign out_load = out_free &&
                      ((r_state == BK_IDLE && o_pop && i_q_status != ST_FREQ) ||
                       (r_state == BK_DONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= out_load;
            end
            unique case (r_state)
                BK_IDLE: begin
                    if (o_pop && i_q_status == ST_FREQ) begin
                        r_state <= BK_CALC;
                        r_step  <= '0;
                    end
                end
                BK_CALC: begin
                    r_step <= r_step + IDXW'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= BK_DONE;
                    end
                end
                BK_DONE: begin
                    if (out_free) begin
                        r_state <= BK_IDLE;
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

    // datapath: most significant pair first, one multiply-add per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == BK_IDLE && o_pop) begin
            r_sh  <= i_q_digits;
            r_acc <= '0;
        end else if (r_state == BK_CALC) begin
            r_sh  <= {r_sh[FREQ_BYTES-2:0], t_byte'(0)};
            r_acc <= r_acc * PAIR_SCALE + pair_val;
        end
        if (out_load) begin
            if (r_state == BK_DONE) begin
                r_status <= ST_FREQ;
                r_freq   <= r_acc;
            end else begin
                r_status <= i_q_status;
                r_freq   <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_frequency = r_freq;

endmodule

`default_nettype wire

@@ rtl/core/bcd_frequency_reply_parser.sv @@
// ----------------------------------------------------------------------------
// bcd_frequency_reply_parser
// parses rig reply frames and reports frequency, ack, refusal or malformed
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. The front end tracks the frame, checks
// destination and source against the two address registers and, on the
// closing 0xFD of a matching frame, pushes one job into a two-entry queue;
// the input stalls only while that queue is full. The back end turns a
// frequency job into hertz with one multiply-by-100-and-add per cycle. A
// frequency result leaves the done state for the output register, others
// load it when their job is taken. Frames take at least eleven bytes
// for a frequency reply, so the decode loop keeps pace with a full-rate byte
// stream. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "bcd_frequency_reply_parser_assert.svh"

module bcd_frequency_reply_parser #(
    parameter int FREQ_BYTES = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire bfrp_pkg::t_byte       i_rx_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output bfrp_pkg::t_status          o_status,
    output bfrp_pkg::t_freq            o_frequency,
    input  wire logic                  i_cfg_we,
    input  wire bfrp_pkg::t_cfg_idx    i_cfg_index,
    input  wire bfrp_pkg::t_byte       i_cfg_data
);
    import bfrp_pkg::*;

    localparam int JOB_W = 2 + FREQ_BYTES * 8;

    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_valid;
    t_status                    push_status;
    logic [FREQ_BYTES-1:0][7:0] push_digits;
    logic [JOB_W-1:0]           q_data;
    t_status                    q_status;
    logic [FREQ_BYTES-1:0][7:0] q_digits;
    logic                       nonfreq_out;

    bfrp_front #(
        .FREQ_BYTES (FREQ_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (q_push),
        .o_job_status (push_status),
        .o_job_digits (push_digits)
    );

    bfrp_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({push_status, push_digits}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_status = q_data[JOB_W-1 -: 2];
    assign q_digits = q_data[JOB_W-3:0];

    bfrp_back #(
        .FREQ_BYTES (FREQ_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_status  (q_status),
        .i_q_digits  (q_digits),
        .i_out_stall (i_out_stall),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_frequency (o_frequency)
    );

    assign nonfreq_out = o_out_valid && (o_status != ST_FREQ);

    // non-frequency results carry zero frequency
    `BFRP_ASSERT_NOW(a_zero_freq, i_clk, i_rst_n, nonfreq_out, o_frequency == '0, "freq not zero")
    // front end never pushes into a full queue
    `BFRP_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, q_push, !q_full, "push into full queue")
    // back end only pops a present job
    `BFRP_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, q_pop, q_valid, "pop from empty queue")
    // a push with no pop leaves the queue holding a job
    `BFRP_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, q_push && !q_pop, q_valid, "job not queued")

endmodule

`default_nettype wire
